// ----- rtl/ddr_pkg.sv -----
// ============================================================================
// ddr_pkg: shared types and constants for the double-density relaxation block
// Holds the buffer geometry, item layouts, sequencer states and the
// saturation and magnitude helpers.
// ============================================================================
package ddr_pkg;

  // Neighbor buffer geometry
  localparam int MaxNb = 32;
  localparam int CntW  = $clog2(MaxNb + 1);
  localparam int IdxW  = (MaxNb > 1) ? $clog2(MaxNb) : 1;

  // Kernel weights
  localparam int WDens      = 20;
  localparam int WNear      = 30;
  localparam int WShiftNear = 53;
  localparam int WShift     = 35;

  // Input item layout on s_axis_tdata
  localparam int OwnLo  = 0;
  localparam int RLo    = 31;
  localparam int DxLo   = 62;
  localparam int DyLo   = 94;
  localparam int MassLo = 126;
  localparam int PLo    = 157;
  localparam int PnLo   = 189;
  localparam int InW    = 224;
  localparam int OutW   = 128;

  localparam int CfgAddrW = 3;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_DT_SQ  = 3'd0,
    CFG_RADIUS = 3'd1,
    CFG_KP     = 3'd2,
    CFG_KN     = 3'd3,
    CFG_REST   = 3'd4,
    CFG_TGAIN  = 3'd5,
    CFG_MTYPE  = 3'd6
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_A_DIV, S_A_SQ, S_A_CU, S_A_DN, S_A_NR, S_A_ACC,
    S_F_RHO, S_F_X, S_WM_HI, S_WM_LO, S_WM_SAT,
    S_B_RD, S_B_PRE, S_B_DIV, S_B_SQ, S_B_CU, S_B_N1, S_B_N2, S_B_N3,
    S_B_DEN, S_B_NX, S_B_QX, S_B_DX, S_B_AX, S_B_QY, S_B_DY, S_B_AY,
    S_B_TX, S_B_TY, S_OUT
  } ddr_state_e;

  // Where the wide multiply sub-sequence returns to
  typedef enum logic [1:0] {
    WR_P, WR_PN, WR_D
  } wret_e;

  typedef struct packed {
    logic [31:0] np;
    logic [31:0] p;
    logic [30:0] m;
    logic [31:0] dy;
    logic [31:0] dx;
    logic [30:0] r;
  } nb_rec_t;

  // Saturate a sign-magnitude value to signed 32 bits
  function automatic logic [31:0] sat_mag(input logic neg, input logic [64:0] mag);
    logic [31:0] res;
    if (neg) begin
      if (mag >= 65'h80000000) res = 32'h80000000;
      else res = ~mag[31:0] + 32'd1;
    end else begin
      if (mag >= 65'h7FFFFFFF) res = 32'h7FFFFFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

  // Saturate a signed 50-bit value to signed 32 bits
  function automatic logic [31:0] sat_sgn(input logic signed [49:0] v);
    logic [31:0] res;
    if (v > 50'sh7FFFFFFF) res = 32'h7FFFFFFF;
    else if (v < -50'sh80000000) res = 32'h80000000;
    else res = v[31:0];
    return res;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    logic [31:0] res;
    res = v[31] ? (~v + 32'd1) : v;
    return res;
  endfunction

  function automatic logic [32:0] abs33(input logic [32:0] v);
    logic [32:0] res;
    res = v[32] ? (~v + 33'd1) : v;
    return res;
  endfunction

endpackage

// ----- rtl/double_density_relaxation_top.sv -----
// ============================================================================
// double_density_relaxation_top: double-density relaxation for one particle
// Buffers the neighbor items of a particle, accumulates density and near
// density, forms the pressures and sums the displacement on one shared
// multiplier and one shared restoring divider under a small sequencer.
// ============================================================================
//
// Channel      Dir  Handshake            Payload
// s_axis       in   tvalid/tready        tdata: neighbor record, tuser: has_neighbor,
//                                        tlast: last_neighbor
// m_axis       out  tvalid/tready        tdata: pressures and shift
// cfg          in   cfg_we_i (no wait)   cfg_addr_i register index, cfg_data_i value
//
// Sequence: a buffered neighbor is accepted, then takes 16 divider steps for
// a = 1 - r/h, four multiplies and the accumulate; a skipped one is only accepted.
// Finishing a particle forms the pressures, then for each buffered neighbor runs
// three passes of the bit-serial divider (16 + 31 + 31 steps; a saturated or
// zero-divisor quotient skips its 31), and ends in the output state.
// s_axis_tready is high only while idle.
// Reset: async; clears sequencer, accumulators, counts, valid, config; h_q = 0x10000.
// A finished result waits in the output register; the next particle is taken
// meanwhile and only its own finish waits on a full output register.
module double_density_relaxation_top import ddr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // own_mass, nb_distance, nb_dx, nb_dy, nb_mass, nb_pressure, nb_near_pressure
  input  logic [InW-1:0]      s_axis_tdata,
  // has_neighbor
  input  logic                s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pressure_out, near_pressure_out, shift_x, shift_y
  output logic [OutW-1:0]     m_axis_tdata
);

  ddr_state_e state_q, state_d;

  // Configuration registers
  logic [30:0] dt_q, h_q, kp_q, kn_q, rest_q;
  logic [31:0] tg_q;
  logic        mt_q;

  // Particle state
  logic [CntW-1:0] cnt_q, j_q;
  logic [47:0]     dens_q, near_q;
  logic [30:0]     own_q, m_q;
  logic            last_q;

  // Neighbor buffer
  nb_rec_t mem_q [MaxNb];
  nb_rec_t rd_q;

  // Shared divider
  logic [61:0] rem_q, den_q;
  logic [30:0] feed_q;
  logic [31:0] quo_q;
  logic [4:0]  dcnt_q;
  logic        azero_q;

  // Shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p_q;

  // Wide multiply sub-sequence
  logic [48:0] wx_q;
  logic        wneg_q, whalf_q;
  logic [30:0] wk_q;
  wret_e       wret_q;
  logic [47:0] whi_q;

  // Pass-two working values
  logic [16:0]        a_q, a2_q, a3_q;
  logic [31:0]        p_q, pn_q, d_q, sx_q, sy_q;
  logic [32:0]        psm_q, pnm_q;
  logic               psn_q, pnn_q, tneg_q;
  logic signed [40:0] inner_q;

  logic [OutW-1:0] out_q;
  logic            mv_q;

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic        in_acc, take;
  logic [30:0] in_r;
  logic [16:0] a_w;
  logic [62:0] rem2;
  logic        div_ge;
  logic [64:0] wm_sum, wm_mag;
  logic [31:0] wm_res;
  logic signed [49:0] x_s;
  logic [31:0] dmag, dxm, dym, tgm;
  logic [63:0] n_w;
  logic        q_skip;
  logic        ten_on;
  logic [48:0] dens_sum, near_sum;
  logic signed [49:0] sx_w, sy_w, qv_w, tm_w;
  logic [32:0] ps_w, pns_w;
  logic [38:0] tn_w, t2_w;
  logic signed [40:0] inr_w;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_r   = s_axis_tdata[RLo +: 31];
  assign take   = s_axis_tuser && (in_r <= h_q) && (cnt_q != CntW'(MaxNb));

  // a = 1 - q, where q = floor(r * 2^16 / h); zero when r >= h or h = 0
  assign a_w = azero_q ? 17'd0 : (17'h10000 - {1'b0, quo_q[15:0]});

  assign rem2   = {rem_q, feed_q[30]};
  assign div_ge = rem2 >= {1'b0, den_q};

  assign wm_sum = {1'b0, whi_q, 16'b0} + {16'b0, mul_p_q[64:16]};
  assign wm_mag = whalf_q ? {1'b0, wm_sum[64:1]} : wm_sum;
  assign wm_res = sat_mag(wneg_q, wm_mag);

  assign x_s = $signed({2'b0, dens_q}) - $signed({4'b0, mul_p_q[61:16]});

  assign dmag = abs32(d_q);
  assign dxm  = abs32(rd_q.dx);
  assign dym  = abs32(rd_q.dy);
  assign tgm  = abs32(tg_q);

  assign n_w    = mul_p_q[63:0];
  assign q_skip = (den_q == 62'd0) || ({13'b0, n_w[63:15]} >= den_q);
  assign ten_on = mt_q && (own_q == rd_q.m);

  assign dens_sum = {1'b0, dens_q} + {12'b0, 37'(mul_p_q[47:16]) * 37'(WDens)};
  assign near_sum = {1'b0, near_q} + {12'b0, 37'(mul_p_q[47:16]) * 37'(WNear)};

  assign sx_w = $signed({{18{sx_q[31]}}, sx_q});
  assign sy_w = $signed({{18{sy_q[31]}}, sy_q});
  assign qv_w = $signed({18'b0, quo_q});
  assign tm_w = $signed({2'b0, mul_p_q[63:16]});

  assign ps_w  = {p_q[31], p_q} + {rd_q.p[31], rd_q.p};
  assign pns_w = {pn_q[31], pn_q} + {rd_q.np[31], rd_q.np};

  assign tn_w  = 39'(mul_p_q[48:16]) * 39'(WShiftNear);
  assign t2_w  = 39'(mul_p_q[48:16]) * 39'(WShift);
  assign inr_w = inner_q + (psn_q ? -$signed({2'b0, t2_w}) : $signed({2'b0, t2_w}));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (take) state_d = S_A_DIV;
          else if (!s_axis_tuser || s_axis_tlast) state_d = S_F_RHO;
        end
      end
      S_A_DIV:  if (dcnt_q == 5'd1) state_d = S_A_SQ;
      S_A_SQ:   state_d = S_A_CU;
      S_A_CU:   state_d = S_A_DN;
      S_A_DN:   state_d = S_A_NR;
      S_A_NR:   state_d = S_A_ACC;
      S_A_ACC:  state_d = last_q ? S_F_RHO : S_IDLE;
      S_F_RHO:  state_d = S_F_X;
      S_F_X:    state_d = S_WM_HI;
      S_WM_HI:  state_d = S_WM_LO;
      S_WM_LO:  state_d = S_WM_SAT;
      S_WM_SAT: begin
        case (wret_q)
          WR_P:    state_d = S_WM_HI;
          WR_PN:   state_d = (cnt_q == '0) ? S_OUT : S_B_RD;
          WR_D:    state_d = S_B_DEN;
          default: state_d = S_IDLE;
        endcase
      end
      S_B_RD:   state_d = S_B_PRE;
      S_B_PRE:  state_d = S_B_DIV;
      S_B_DIV:  if (dcnt_q == 5'd1) state_d = S_B_SQ;
      S_B_SQ:   state_d = S_B_CU;
      S_B_CU:   state_d = S_B_N1;
      S_B_N1:   state_d = S_B_N2;
      S_B_N2:   state_d = S_B_N3;
      S_B_N3:   state_d = S_WM_HI;
      S_B_DEN:  state_d = S_B_NX;
      S_B_NX:   state_d = S_B_QX;
      S_B_QX:   state_d = q_skip ? S_B_AX : S_B_DX;
      S_B_DX:   if (dcnt_q == 5'd1) state_d = S_B_AX;
      S_B_AX:   state_d = S_B_QY;
      S_B_QY:   state_d = q_skip ? S_B_AY : S_B_DY;
      S_B_DY:   if (dcnt_q == 5'd1) state_d = S_B_AY;
      S_B_AY:   state_d = S_B_TX;
      S_B_TX:   state_d = S_B_TY;
      S_B_TY:   state_d = ((j_q + CntW'(1)) == cnt_q) ? S_OUT : S_B_RD;
      S_OUT:    if (!mv_q || m_axis_tready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs: handshake and multiplier operand select
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_A_SQ, S_B_SQ: begin
        mul_a = {16'b0, a_w};
        mul_b = {15'b0, a_w};
      end
      S_A_CU, S_B_CU: begin
        mul_a = {16'b0, mul_p_q[32:16]};
        mul_b = {15'b0, a_q};
      end
      S_A_DN: begin
        mul_a = {16'b0, a2_q};
        mul_b = {1'b0, m_q};
      end
      S_A_NR: begin
        mul_a = {16'b0, a3_q};
        mul_b = {1'b0, m_q};
      end
      S_F_RHO: begin
        mul_a = {2'b0, own_q};
        mul_b = {1'b0, rest_q};
      end
      S_WM_HI: begin
        mul_a = {16'b0, wx_q[48:32]};
        mul_b = {1'b0, wk_q};
      end
      S_WM_LO: begin
        mul_a = {1'b0, wx_q[31:0]};
        mul_b = {1'b0, wk_q};
      end
      S_B_N1: begin
        mul_a = pnm_q;
        mul_b = {15'b0, mul_p_q[32:16]};
      end
      S_B_N2: begin
        mul_a = psm_q;
        mul_b = {15'b0, a2_q};
      end
      S_B_DEN: begin
        mul_a = {2'b0, rd_q.r};
        mul_b = {1'b0, own_q};
      end
      S_B_NX: begin
        mul_a = {1'b0, dmag};
        mul_b = dxm;
      end
      S_B_AX: begin
        mul_a = {1'b0, dmag};
        mul_b = dym;
      end
      S_B_AY: begin
        mul_a = {1'b0, dxm};
        mul_b = tgm;
      end
      S_B_TX: begin
        mul_a = {1'b0, dym};
        mul_b = tgm;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dt_q    <= '0;
      h_q     <= 31'h10000;
      kp_q    <= '0;
      kn_q    <= '0;
      rest_q  <= '0;
      tg_q    <= '0;
      mt_q    <= 1'b0;
      cnt_q   <= '0;
      j_q     <= '0;
      dens_q  <= '0;
      near_q  <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_DT_SQ:  dt_q   <= cfg_data_i[30:0];
          CFG_RADIUS: h_q    <= cfg_data_i[30:0];
          CFG_KP:     kp_q   <= cfg_data_i[30:0];
          CFG_KN:     kn_q   <= cfg_data_i[30:0];
          CFG_REST:   rest_q <= cfg_data_i[30:0];
          CFG_TGAIN:  tg_q   <= cfg_data_i;
          CFG_MTYPE:  mt_q   <= cfg_data_i[0];
          default: ;
        endcase
      end

      // Load a new result, or drop the one just taken
      if (state_q == S_OUT && (!mv_q || m_axis_tready)) mv_q <= 1'b1;
      else if (mv_q && m_axis_tready) mv_q <= 1'b0;

      case (state_q)
        S_IDLE:   if (in_acc && take) cnt_q <= cnt_q + CntW'(1);
        S_A_NR:   dens_q <= dens_sum[48] ? '1 : dens_sum[47:0];
        S_A_ACC:  near_q <= near_sum[48] ? '1 : near_sum[47:0];
        S_WM_SAT: if (wret_q == WR_PN) j_q <= '0;
        S_B_TY:   j_q <= j_q + CntW'(1);
        S_OUT: begin
          if (!mv_q || m_axis_tready) begin
            cnt_q  <= '0;
            dens_q <= '0;
            near_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Neighbor buffer: written on accept, read once per pass-two neighbor
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc && take) begin
      mem_q[cnt_q[IdxW-1:0]] <= '{np: s_axis_tdata[PnLo +: 32],
                                  p:  s_axis_tdata[PLo +: 32],
                                  m:  s_axis_tdata[MassLo +: 31],
                                  dy: s_axis_tdata[DyLo +: 32],
                                  dx: s_axis_tdata[DxLo +: 32],
                                  r:  in_r};
    end
    if (state_q == S_B_RD) rd_q <= mem_q[j_q[IdxW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_a * mul_b;

    // Divider step: shift in one numerator bit, subtract when it fits
    if (state_q inside {S_A_DIV, S_B_DIV, S_B_DX, S_B_DY}) begin
      rem_q  <= div_ge ? 62'(rem2 - {1'b0, den_q}) : rem2[61:0];
      quo_q  <= {quo_q[30:0], div_ge};
      feed_q <= {feed_q[29:0], 1'b0};
      dcnt_q <= dcnt_q - 5'd1;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          own_q   <= s_axis_tdata[OwnLo +: 31];
          m_q     <= s_axis_tdata[MassLo +: 31];
          last_q  <= s_axis_tlast;
          rem_q   <= {31'b0, in_r};
          den_q   <= {31'b0, h_q};
          feed_q  <= '0;
          quo_q   <= '0;
          dcnt_q  <= 5'd16;
          azero_q <= (h_q == 31'd0) || (in_r >= h_q);
        end
      end
      S_A_SQ, S_B_SQ: a_q <= a_w;
      S_A_CU, S_B_CU: a2_q <= mul_p_q[32:16];
      S_A_DN: a3_q <= mul_p_q[32:16];
      S_F_RHO: begin
        sx_q <= '0;
        sy_q <= '0;
      end
      S_F_X: begin
        wneg_q  <= x_s[49];
        wx_q    <= x_s[49] ? 49'(-x_s) : x_s[48:0];
        wk_q    <= kp_q;
        whalf_q <= 1'b0;
        wret_q  <= WR_P;
      end
      S_WM_LO: whi_q <= mul_p_q[47:0];
      S_WM_SAT: begin
        case (wret_q)
          WR_P: begin
            p_q     <= wm_res;
            wneg_q  <= 1'b0;
            wx_q    <= {1'b0, near_q};
            wk_q    <= kn_q;
            wret_q  <= WR_PN;
          end
          WR_PN:   pn_q <= wm_res;
          WR_D:    d_q  <= wm_res;
          default: ;
        endcase
      end
      S_B_PRE: begin
        psn_q   <= ps_w[32];
        psm_q   <= abs33(ps_w);
        pnn_q   <= pns_w[32];
        pnm_q   <= abs33(pns_w);
        rem_q   <= {31'b0, rd_q.r};
        den_q   <= {31'b0, h_q};
        feed_q  <= '0;
        quo_q   <= '0;
        dcnt_q  <= 5'd16;
        azero_q <= (h_q == 31'd0) || (rd_q.r >= h_q);
      end
      S_B_N2: inner_q <= pnn_q ? -$signed({2'b0, tn_w}) : $signed({2'b0, tn_w});
      S_B_N3: begin
        wneg_q  <= inr_w[40];
        wx_q    <= {9'b0, inr_w[40] ? 40'(-inr_w) : inr_w[39:0]};
        wk_q    <= dt_q;
        whalf_q <= 1'b1;
        wret_q  <= WR_D;
      end
      S_B_NX: den_q <= mul_p_q[61:0];
      S_B_QX, S_B_QY: begin
        tneg_q <= d_q[31] ^ ((state_q == S_B_QX) ? rd_q.dx[31] : rd_q.dy[31]);
        if (den_q == 62'd0) begin
          quo_q <= '0;
        end else if (q_skip) begin
          quo_q <= 32'h80000000;
        end else begin
          rem_q  <= {13'b0, n_w[63:15]};
          feed_q <= {n_w[14:0], 16'b0};
          quo_q  <= '0;
          dcnt_q <= 5'd31;
        end
      end
      S_B_AX: sx_q <= sat_sgn(tneg_q ? (sx_w + qv_w) : (sx_w - qv_w));
      S_B_AY: sy_q <= sat_sgn(tneg_q ? (sy_w + qv_w) : (sy_w - qv_w));
      S_B_TX: begin
        if (ten_on) sx_q <= sat_sgn((rd_q.dx[31] ^ tg_q[31]) ? (sx_w - tm_w) : (sx_w + tm_w));
      end
      S_B_TY: begin
        if (ten_on) sy_q <= sat_sgn((rd_q.dy[31] ^ tg_q[31]) ? (sy_w - tm_w) : (sy_w + tm_w));
      end
      S_OUT: if (!mv_q || m_axis_tready) out_q <= {sy_q, sx_q, pn_q, p_q};
      default: ;
    endcase
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- rtl/ddr_checker.sv -----
// ============================================================================
// ddr_props: port-level checks for the double-density relaxation block
// Watches the stream handshakes and the result timing.
// ============================================================================
module ddr_props import ddr_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A result never appears right after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result raised one cycle after accept");

  // A new result is produced only while the block is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result raised from idle");

endmodule

bind double_density_relaxation_top ddr_props u_ddr_props (.*);

// ----- tb/ddr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddr_checker: scoreboard for the double-density relaxation block
// Tracks register writes and accepted neighbor items, predicts the pressures
// and displacement of each finished particle and compares them with the
// results the block emits.
// ----------------------------------------------------------------------------
module ddr_checker import ddr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InW-1:0]      s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                s_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutW-1:0]     m_axis_tdata,
  output int                  err_cnt_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [31:0] sy;
    logic [31:0] sx;
    logic [31:0] pn;
    logic [31:0] p;
  } relax_res_t;

  localparam longint unsigned QOne   = 64'd65536;
  localparam longint unsigned Acc48  = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned MagCap = 64'h4000_0000_0000_0000;

  relax_res_t expected_relax_q[$];

  longint unsigned dt_sq, radius, kp, kn, rest, mtype;
  longint          tgain;
  logic [31:0]     nb_r[MaxNb], nb_dx[MaxNb], nb_dy[MaxNb];
  logic [31:0]     nb_m[MaxNb], nb_p[MaxNb], nb_pn[MaxNb];
  int unsigned     nb_cnt;
  longint unsigned rho_acc, rho_near_acc;

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned umag(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned umul16(input longint unsigned x, input longint unsigned k);
    longint unsigned r;
    r = (x >> 16) * k + (((x & 64'hFFFF) * k) >> 16);
    return (r > MagCap) ? MagCap : r;
  endfunction

  // Q16.16 product, rounded toward zero
  function automatic longint smul(input longint x, input longint k);
    longint m;
    m = longint'(umul16(umag(x), umag(k)));
    return ((x < 0) != (k < 0)) ? -m : m;
  endfunction

  // floor(n * 2^16 / d), capped at 2^31
  function automatic longint unsigned udivq(input longint unsigned n, input longint unsigned d);
    longint unsigned q, rem;
    q = n / d;
    rem = n % d;
    if (q >= 64'h8000_0000) return 64'h8000_0000;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 64'd1;
      end
    end
    return (q > 64'h8000_0000) ? 64'h8000_0000 : q;
  endfunction

  function automatic longint unsigned kernel_weight(input longint unsigned r);
    longint unsigned q;
    if (radius == 0) return 0;
    q = (r << 16) / radius;
    if (q > QOne) q = QOne;
    return QOne - q;
  endfunction

  function automatic longint unsigned add_sat48(input longint unsigned acc,
                                                input longint unsigned v);
    longint unsigned s;
    s = acc + v;
    return (s > Acc48) ? Acc48 : s;
  endfunction

  function automatic longint displacement(input longint d, input longint diff,
                                          input longint unsigned r,
                                          input longint unsigned own);
    longint unsigned den;
    longint t;
    den = r * own;
    if (den == 0) return 0;
    t = longint'(udivq(umag(d) * umag(diff), den));
    return ((d < 0) != (diff < 0)) ? -t : t;
  endfunction

  // Take one neighbor item; returns 1 with the particle's result when it finishes
  function automatic bit predict_relaxation(input logic [InW-1:0] data, input logic has,
                                            input logic last, output relax_res_t res);
    longint unsigned own, r, m, a, a2, a3;
    longint p, pn, sx, sy, dxv, dyv, inner, d;
    own = data[OwnLo +: 31];
    sx = 0;
    sy = 0;
    res = '0;
    if (has) begin
      r = data[RLo +: 31];
      if (r <= radius && nb_cnt < MaxNb) begin
        m = data[MassLo +: 31];
        a = kernel_weight(r);
        a2 = (a * a) >> 16;
        a3 = (a2 * a) >> 16;
        nb_r[nb_cnt]  = {1'b0, data[RLo +: 31]};
        nb_dx[nb_cnt] = data[DxLo +: 32];
        nb_dy[nb_cnt] = data[DyLo +: 32];
        nb_m[nb_cnt]  = {1'b0, data[MassLo +: 31]};
        nb_p[nb_cnt]  = data[PLo +: 32];
        nb_pn[nb_cnt] = data[PnLo +: 32];
        nb_cnt++;
        rho_acc = add_sat48(rho_acc, ((a2 * m) >> 16) * WDens);
        rho_near_acc = add_sat48(rho_near_acc, ((a3 * m) >> 16) * WNear);
      end
      if (!last) return 0;
    end
    p = sat32(smul(longint'(rho_acc) - longint'((own * rest) >> 16), longint'(kp)));
    pn = sat32(smul(longint'(rho_near_acc), longint'(kn)));
    for (int unsigned j = 0; j < nb_cnt; j++) begin
      r = nb_r[j];
      a = kernel_weight(r);
      a2 = (a * a) >> 16;
      a3 = (a2 * a) >> 16;
      dxv = longint'($signed(nb_dx[j]));
      dyv = longint'($signed(nb_dy[j]));
      inner = smul(pn + longint'($signed(nb_pn[j])), longint'(a3)) * WShiftNear
            + smul(p + longint'($signed(nb_p[j])), longint'(a2)) * WShift;
      d = sat32(smul(inner, longint'(dt_sq)) / 2);
      sx = sat32(sx - displacement(d, dxv, r, own));
      sy = sat32(sy - displacement(d, dyv, r, own));
      if (mtype != 0 && own == longint'(nb_m[j])) begin
        sx = sat32(sx + smul(dxv, tgain));
        sy = sat32(sy + smul(dyv, tgain));
      end
    end
    nb_cnt = 0;
    rho_acc = 0;
    rho_near_acc = 0;
    res.p  = p[31:0];
    res.pn = pn[31:0];
    res.sx = sx[31:0];
    res.sy = sy[31:0];
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    relax_res_t res, got;
    int errs;
    if (!rst_ni) begin
      dt_sq <= 0;
      radius <= QOne;
      kp <= 0;
      kn <= 0;
      rest <= 0;
      tgain <= 0;
      mtype <= 0;
      nb_cnt <= 0;
      rho_acc <= 0;
      rho_near_acc <= 0;
      expected_relax_q.delete();
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_DT_SQ:  dt_sq = cfg_data_i[30:0];
          CFG_RADIUS: radius = cfg_data_i[30:0];
          CFG_KP:     kp = cfg_data_i[30:0];
          CFG_KN:     kn = cfg_data_i[30:0];
          CFG_REST:   rest = cfg_data_i[30:0];
          CFG_TGAIN:  tgain = longint'($signed(cfg_data_i));
          CFG_MTYPE:  mtype = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_relaxation(s_axis_tdata, s_axis_tuser, s_axis_tlast, res))
          expected_relax_q.push_back(res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_relax_q.size() == 0) begin
          $error("unexpected result item %h", m_axis_tdata);
          errs++;
        end else begin
          res = expected_relax_q.pop_front();
          if (got.p !== res.p) begin
            $error("pressure_out: expected %h, actual %h", res.p, got.p);
            errs++;
          end
          if (got.pn !== res.pn) begin
            $error("near_pressure_out: expected %h, actual %h", res.pn, got.pn);
            errs++;
          end
          if (got.sx !== res.sx) begin
            $error("shift_x: expected %h, actual %h", res.sx, got.sx);
            errs++;
          end
          if (got.sy !== res.sy) begin
            $error("shift_y: expected %h, actual %h", res.sy, got.sy);
            errs++;
          end
        end
      end
      err_cnt_o <= err_cnt_o + errs;
      pending_o <= expected_relax_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for double_density_relaxation_top
// Streams neighbor lists of particles under several register settings, with
// random idling on both channels and one long output stall; the checker
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
  import ddr_pkg::*;

  localparam int          ItemsPerPhase = 130;
  localparam int          WatchLimit    = 20000;
  localparam int          HoldCycles    = 800;
  localparam logic [30:0] Max31         = 31'h7FFF_FFFF;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [31:0]         cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // own_mass, nb_distance, nb_dx, nb_dy, nb_mass, nb_pressure, nb_near_pressure
  logic [InW-1:0]      s_axis_tdata = '0;
  // has_neighbor
  logic                s_axis_tuser = 1'b0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // pressure_out, near_pressure_out, shift_x, shift_y
  logic [OutW-1:0]     m_axis_tdata;
  int                  err_cnt, pending;

  int                  items_sent = 0;
  logic [30:0]         cur_radius = 31'd65536;
  bit                  cur_mtype = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  double_density_relaxation_top u_dut (.*);

  ddr_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  // Watchdog: end the run if no item moves on either channel for too long
  always @(posedge clk_i) begin
    int idle_cycles;
    if (rst_ni && !((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))) begin
      idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("FAIL double_density_relaxation_top");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // Receiver: random stalls, runs of no stall, and one long hold-off
  // so the block fills its output register and stops taking items
  initial begin
    int results;
    int gap;
    bit no_stall;
    results = 0;
    no_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (results % 25 == 0) no_stall = ($urandom_range(0, 2) == 0);
      gap = no_stall ? 0 : $urandom_range(0, 14);
      if (results == 40) gap = HoldCycles;
      if (gap > 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_axis_tready <= 1'b1;
      while (!m_axis_tvalid) @(negedge clk_i);
      @(posedge clk_i);
      results++;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    if (idx == CFG_RADIUS) cur_radius = val[30:0];
    if (idx == CFG_MTYPE) cur_mtype = val[0];
  endtask

  // Offer one item after a random gap, none in a burst; return once it is accepted
  task automatic send_item(input bit burst, input logic [30:0] own, input bit has,
                           input logic [30:0] r, input logic [31:0] dx, input logic [31:0] dy,
                           input logic [30:0] m, input logic [31:0] p, input logic [31:0] pn,
                           input bit last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, pn, p, m, dy, dx, r, own};
    s_axis_tuser <= has;
    s_axis_tlast <= last;
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  // Drain: drop valid, wait for every result, then let a trailing neighbor finish
  task automatic settle();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_val(input bit wide);
    return wide ? $urandom : ($urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
  endfunction

  function automatic logic [30:0] pick_mass(input bit wide);
    return wide ? 31'($urandom_range(1, Max31)) : 31'($urandom_range(32'h1000, 32'h4_0000));
  endfunction

  // Mostly inside the kernel; also on the rim, at zero and beyond it
  function automatic logic [30:0] pick_dist();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 31'd0;
    if (roll == 1) return cur_radius;
    if (roll == 2 && cur_radius != Max31) return 31'($urandom_range(cur_radius + 1, Max31));
    return 31'($urandom_range(0, cur_radius));
  endfunction

  task automatic send_particle();
    int n, roll;
    bit burst, by_empty, wide, last;
    logic [30:0] own, m;
    roll = $urandom_range(0, 99);
    if (roll < 3) n = $urandom_range(33, 36);
    else if (roll < 15) n = 0;
    else n = $urandom_range(1, 6);
    burst = ($urandom_range(0, 3) == 0);
    wide = ($urandom_range(0, 3) == 0);
    by_empty = (n > 0) && ($urandom_range(0, 9) == 0);
    own = pick_mass(wide);
    for (int i = 0; i < n; i++) begin
      last = (i == n - 1) && !by_empty;
      m = (cur_mtype && $urandom_range(0, 2) == 0) ? own : pick_mass(wide);
      send_item(burst, own, 1'b1, pick_dist(), pick_val(wide), pick_val(wide), m,
                pick_val(wide), pick_val(wide), last);
    end
    // Close with an item that carries no neighbor; its other fields are noise
    if (n == 0 || by_empty)
      send_item(burst, own, 1'b0, 31'($urandom), $urandom, $urandom, 31'($urandom),
                $urandom, $urandom, 1'($urandom));
  endtask

  task automatic apply_settings(input int kind);
    case (kind)
      0: begin
        write_reg(CFG_DT_SQ, 32'h0000_4000);
        write_reg(CFG_RADIUS, 32'h0002_0000);
        write_reg(CFG_KP, 32'h0001_8000);
        write_reg(CFG_KN, 32'h0000_C000);
        write_reg(CFG_REST, 32'h0000_2000);
        write_reg(CFG_TGAIN, 32'hFFFF_F000);
        write_reg(CFG_MTYPE, 32'd1);
      end
      1: begin
        write_reg(CFG_DT_SQ, {1'b0, Max31});
        write_reg(CFG_RADIUS, {1'b0, Max31});
        write_reg(CFG_KP, {1'b0, Max31});
        write_reg(CFG_KN, {1'b0, Max31});
        write_reg(CFG_REST, {1'b0, Max31});
        write_reg(CFG_TGAIN, 32'h8000_0000);
        write_reg(CFG_MTYPE, 32'd1);
      end
      2: begin
        write_reg(CFG_DT_SQ, 32'd0);
        write_reg(CFG_RADIUS, 32'd1);
        write_reg(CFG_KP, 32'd0);
        write_reg(CFG_KN, 32'd0);
        write_reg(CFG_REST, 32'd0);
        write_reg(CFG_TGAIN, 32'h7FFF_FFFF);
        write_reg(CFG_MTYPE, 32'd1);
      end
      3: begin
        write_reg(CFG_DT_SQ, $urandom);
        write_reg(CFG_RADIUS, $urandom_range(1, Max31));
        write_reg(CFG_KP, $urandom);
        write_reg(CFG_KN, $urandom);
        write_reg(CFG_REST, $urandom);
        write_reg(CFG_TGAIN, $urandom);
        write_reg(CFG_MTYPE, $urandom);
      end
      default: begin
        write_reg(CFG_DT_SQ, $urandom_range(0, 32'h2_0000));
        write_reg(CFG_RADIUS, $urandom_range(32'h1_0000, 32'h4_0000));
        write_reg(CFG_KP, $urandom_range(0, 32'h4_0000));
        write_reg(CFG_KN, $urandom_range(0, 32'h4_0000));
        write_reg(CFG_REST, $urandom_range(0, 32'h1_0000));
        write_reg(CFG_TGAIN, $urandom_range(0, 32'h2_0000) - 32'h1_0000);
        write_reg(CFG_MTYPE, 32'd0);
      end
    endcase
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Empty particle under reset settings
    send_item(1'b0, 31'h1_0000, 1'b0, '0, '0, '0, 31'd1, '0, '0, 1'b1);
    settle();

    apply_settings(0);
    // Neighbor at zero distance, on the rim, beyond it, and one of extreme fields
    send_item(1'b0, 31'h1_0000, 1'b1, 31'd0, 32'h0000_8000, 32'hFFFF_8000, 31'h1_0000,
              32'h0001_0000, 32'hFFFF_0000, 1'b0);
    send_item(1'b0, 31'h1_0000, 1'b1, 31'h2_0000, 32'h0001_0000, 32'h0, 31'h2_0000,
              32'h0, 32'h0, 1'b0);
    send_item(1'b0, 31'h1_0000, 1'b1, 31'h2_0001, 32'h7FFF_FFFF, 32'h8000_0000, Max31,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_item(1'b1, 31'h1_0000, 1'b1, 31'h1_0000, 32'h7FFF_FFFF, 32'h8000_0000, Max31,
              32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    // Extremes the other way: heaviest particle, lightest neighbor, closest
    send_item(1'b0, Max31, 1'b1, 31'd1, 32'h8000_0000, 32'h7FFF_FFFF, 31'd1,
              32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // Lightest particle with a neighbor of equal mass for surface tension
    send_item(1'b0, 31'd1, 1'b1, 31'h0_8000, 32'hFFFF_FFFF, 32'h0000_0001, 31'd1,
              32'h0, 32'h0, 1'b1);
    // Buffered neighbors then finished by an item without a neighbor
    send_item(1'b0, 31'h2_0000, 1'b1, 31'h1_8000, 32'h0003_0000, 32'h0004_0000, 31'h2_0000,
              32'h0000_1000, 32'h0000_2000, 1'b0);
    send_item(1'b0, 31'h2_0000, 1'b1, 31'h0_4000, 32'hFFFD_0000, 32'h0001_0000, 31'h3_0000,
              32'hFFFF_1000, 32'h0000_0100, 1'b0);
    send_item(1'b0, 31'h2_0000, 1'b0, Max31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, Max31,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    // Particle whose only and last neighbor is far away
    send_item(1'b0, 31'h1_0000, 1'b1, Max31, 32'h1, 32'h1, 31'h1_0000, 32'h1, 32'h1, 1'b1);
    // Empty particle
    send_item(1'b0, 31'h1_0000, 1'b0, '0, '0, '0, 31'd1, '0, '0, 1'b0);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) apply_settings(ph);
      while (items_sent < (ph + 1) * ItemsPerPhase + 12) send_particle();
      settle();
    end

    if (err_cnt == 0 && pending == 0) begin
      $display("PASS double_density_relaxation_top");
    end else begin
      $display("FAIL double_density_relaxation_top");
    end
    $finish;
  end

endmodule
